// ===== src/dtc_pkg.sv =====
`default_nettype none

package dtc_pkg;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_LIM_ONE   = 2'd0;
   localparam logic [1:0] CSR_LIM_TWO   = 2'd1;
   localparam logic [1:0] CSR_LIM_THREE = 2'd2;
   localparam logic [1:0] CSR_LIM_FOUR  = 2'd3;

   // Reset values of the range limits, in ns
   localparam logic [15:0] LIM_ONE_RST   = 16'd756;
   localparam logic [15:0] LIM_TWO_RST   = 16'd1512;
   localparam logic [15:0] LIM_THREE_RST = 16'd3000;
   localparam logic [15:0] LIM_FOUR_RST  = 16'd6000;

   // Operation codes
   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   // Encode: q = floor(ns * 21 / 125) by reciprocal 21/125 * 2^20, then one fixup
   localparam logic [17:0] ENC_RECIP = 18'd176160;
   localparam int          ENC_SHIFT = 20;
   localparam logic [4:0]  ENC_NUM   = 5'd21;
   localparam logic [7:0]  ENC_DEN   = 8'd125;

   // Decode: floor(n / 21) by reciprocal ceil(2^22 / 21), exact for n < 2^17
   localparam logic [17:0] DEC_RECIP = 18'd199729;
   localparam int          DEC_SHIFT = 22;
   localparam logic [16:0] DEC_SCALE_ONE   = 17'd125;
   localparam logic [16:0] DEC_SCALE_TWO   = 17'd250;
   localparam logic [16:0] DEC_SCALE_THREE = 17'd1000;
   localparam logic [16:0] DEC_SCALE_FOUR  = 17'd2000;
   localparam logic [15:0] DEC_MAX_NS      = 16'd6000;

   // Code prefixes, masks and range offsets
   localparam logic [7:0] PREFIX_TWO   = 8'h80;
   localparam logic [7:0] PREFIX_THREE = 8'hC0;
   localparam logic [7:0] PREFIX_FOUR  = 8'hE0;
   localparam logic [7:0] MASK_SIX     = 8'h3F;
   localparam logic [7:0] MASK_FIVE    = 8'h1F;
   localparam logic [6:0] OFFSET_TWO   = 7'd64;
   localparam logic [6:0] OFFSET_LOW   = 7'd32;

   typedef enum logic [2:0] {
      RNG_ONE,
      RNG_TWO,
      RNG_THREE,
      RNG_FOUR,
      RNG_NONE
   } range_type;

   typedef struct packed {
      logic [15:0] one;
      logic [15:0] two;
      logic [15:0] three;
      logic [15:0] four;
   } limits_type;

endpackage

`default_nettype wire

// ===== src/dtc_csr_regs.sv =====
`default_nettype none

module dtc_csr_regs
   import dtc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data,
   output limits_type       limits
);

   logic [15:0] lim_one_ff,   lim_one_in;
   logic [15:0] lim_two_ff,   lim_two_in;
   logic [15:0] lim_three_ff, lim_three_in;
   logic [15:0] lim_four_ff,  lim_four_in;

   // Decode the write beat
   always_comb begin
      lim_one_in   = lim_one_ff;
      lim_two_in   = lim_two_ff;
      lim_three_in = lim_three_ff;
      lim_four_in  = lim_four_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LIM_ONE:   lim_one_in   = csr_write_data;
            CSR_LIM_TWO:   lim_two_in   = csr_write_data;
            CSR_LIM_THREE: lim_three_in = csr_write_data;
            CSR_LIM_FOUR:  lim_four_in  = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_one_ff   <= LIM_ONE_RST;
         lim_two_ff   <= LIM_TWO_RST;
         lim_three_ff <= LIM_THREE_RST;
         lim_four_ff  <= LIM_FOUR_RST;
      end else begin
         lim_one_ff   <= lim_one_in;
         lim_two_ff   <= lim_two_in;
         lim_three_ff <= lim_three_in;
         lim_four_ff  <= lim_four_in;
      end
   end

   assign limits.one   = lim_one_ff;
   assign limits.two   = lim_two_ff;
   assign limits.three = lim_three_ff;
   assign limits.four  = lim_four_ff;

endmodule

`default_nettype wire

// ===== src/dtc_enc_lane.sv =====
`default_nettype none

module dtc_enc_lane
   import dtc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [15:0] ns_in,
   input  wire limits_type  limits,
   output logic [7:0]       code_out
);

   // Stage 1 registers
   logic [33:0] prod_s1_ff, prod_s1_in;
   logic [20:0] num_s1_ff,  num_s1_in;
   range_type   rng_s1_ff,  rng_s1_in;

   // Stage 2 registers
   logic [13:0] qest_s2_ff, qest_s2_in;
   logic        fix_s2_ff,  fix_s2_in;
   range_type   rng_s2_ff;

   logic [20:0] qden;
   logic [20:0] rem;
   logic [13:0] quot;
   logic [12:0] cnt_two;
   logic [10:0] cnt_three;
   logic [9:0]  cnt_four;
   logic [5:0]  fld_two;
   logic [4:0]  fld_three;
   logic [4:0]  fld_four;

   // Pick the range and start the reciprocal multiply
   always_comb begin
      if (ns_in < limits.one) begin
         rng_s1_in = RNG_ONE;
      end else if (ns_in < limits.two) begin
         rng_s1_in = RNG_TWO;
      end else if (ns_in < limits.three) begin
         rng_s1_in = RNG_THREE;
      end else if (ns_in < limits.four) begin
         rng_s1_in = RNG_FOUR;
      end else begin
         rng_s1_in = RNG_NONE;
      end
      prod_s1_in = 34'(ns_in) * 34'(ENC_RECIP);
      num_s1_in  = 21'(ns_in) * 21'(ENC_NUM);
   end

   // Estimate the quotient; it is low by at most one, so flag the fixup
   always_comb begin
      qest_s2_in = prod_s1_ff[ENC_SHIFT +: 14];
      qden       = 21'(qest_s2_in) * 21'(ENC_DEN);
      rem        = num_s1_ff - qden;
      fix_s2_in  = (rem >= 21'(ENC_DEN));
   end

   always_ff @(posedge clock) begin
      prod_s1_ff <= prod_s1_in;
      num_s1_ff  <= num_s1_in;
      rng_s1_ff  <= rng_s1_in;
      qest_s2_ff <= qest_s2_in;
      fix_s2_ff  <= fix_s2_in;
      rng_s2_ff  <= rng_s1_ff;
   end

   // Finish the quotient, drop the range offset with a floor at zero, clamp
   always_comb begin
      quot      = qest_s2_ff + 14'(fix_s2_ff);
      cnt_two   = quot[13:1];
      cnt_three = quot[13:3];
      cnt_four  = quot[13:4];

      if (cnt_two <= 13'(OFFSET_TWO)) begin
         fld_two = '0;
      end else if ((cnt_two - 13'(OFFSET_TWO)) > 13'(MASK_SIX)) begin
         fld_two = MASK_SIX[5:0];
      end else begin
         fld_two = 6'(cnt_two - 13'(OFFSET_TWO));
      end

      if (cnt_three <= 11'(OFFSET_LOW)) begin
         fld_three = '0;
      end else if ((cnt_three - 11'(OFFSET_LOW)) > 11'(MASK_FIVE)) begin
         fld_three = MASK_FIVE[4:0];
      end else begin
         fld_three = 5'(cnt_three - 11'(OFFSET_LOW));
      end

      if (cnt_four <= 10'(OFFSET_LOW)) begin
         fld_four = '0;
      end else if ((cnt_four - 10'(OFFSET_LOW)) > 10'(MASK_FIVE)) begin
         fld_four = MASK_FIVE[4:0];
      end else begin
         fld_four = 5'(cnt_four - 10'(OFFSET_LOW));
      end

      unique case (rng_s2_ff)
         RNG_ONE:   code_out = {1'b0, quot[6:0]};
         RNG_TWO:   code_out = PREFIX_TWO | {2'b00, fld_two};
         RNG_THREE: code_out = PREFIX_THREE | {3'b000, fld_three};
         RNG_FOUR:  code_out = PREFIX_FOUR | {3'b000, fld_four};
         default:   code_out = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/dtc_dec_lane.sv =====
`default_nettype none

module dtc_dec_lane
   import dtc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic [7:0] code_in,
   output logic [12:0]     ns_out
);

   logic [16:0] num_s1_ff,  num_s1_in;
   logic [34:0] prod_s2_ff, prod_s2_in;

   // Scale the count of the selected range up to the numerator
   always_comb begin
      if (!code_in[7]) begin
         num_s1_in = 17'(code_in[6:0]) * DEC_SCALE_ONE;
      end else if (!code_in[6]) begin
         num_s1_in = (17'(code_in & MASK_SIX) + 17'(OFFSET_TWO)) * DEC_SCALE_TWO;
      end else if (!code_in[5]) begin
         num_s1_in = (17'(code_in & MASK_FIVE) + 17'(OFFSET_LOW)) * DEC_SCALE_THREE;
      end else begin
         num_s1_in = (17'(code_in & MASK_FIVE) + 17'(OFFSET_LOW)) * DEC_SCALE_FOUR;
      end
   end

   // Divide by 21 through the reciprocal
   assign prod_s2_in = 35'(num_s1_ff) * 35'(DEC_RECIP);

   always_ff @(posedge clock) begin
      num_s1_ff  <= num_s1_in;
      prod_s2_ff <= prod_s2_in;
   end

   assign ns_out = prod_s2_ff[DEC_SHIFT +: 13];

endmodule

`default_nettype wire

// ===== src/dead_time_code_converter_top.sv =====
// A taken start passes valid_s1, valid_s2 and strobe_ff, then strobes a result.
// Throughput: one item per cycle; busy stays low, start may be held every cycle.
// The depth is set by the multipliers; each lane has one reciprocal multiply.
// Reset: synchronous, active high; clears the valid pipeline and sets the
// range limits to 756, 1512, 3000 and 6000 ns. The receiver cannot stall.
`default_nettype none

module dead_time_code_converter_top
   import dtc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [15:0] req_ns_in,
   input  wire logic [7:0]  req_code_in,
   output logic             rsp_strobe,
   output logic [15:0]      rsp_result_value,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   limits_type  limits;
   logic [7:0]  enc_code;
   logic [12:0] dec_ns;
   logic        accept;

   logic        valid_s1_ff, valid_s2_ff;
   logic        kind_s1_ff,  kind_s2_ff;
   logic        strobe_ff;
   logic [15:0] value_ff, value_in;

   dtc_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .limits           (limits)
   );

   dtc_enc_lane u_enc (
      .clock    (clock),
      .ns_in    (req_ns_in),
      .limits   (limits),
      .code_out (enc_code)
   );

   dtc_dec_lane u_dec (
      .clock   (clock),
      .code_in (req_code_in),
      .ns_out  (dec_ns)
   );

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Advance the valid bits with the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         valid_s1_ff <= accept;
         valid_s2_ff <= valid_s1_ff;
         strobe_ff   <= valid_s2_ff;
      end
   end

   // Select the lane for the output beat
   always_comb begin
      if (kind_s2_ff == KIND_DECODE) begin
         value_in = {3'b000, dec_ns};
      end else begin
         value_in = {8'h00, enc_code};
      end
   end

   always_ff @(posedge clock) begin
      kind_s1_ff <= req_kind;
      kind_s2_ff <= kind_s1_ff;
      value_ff   <= value_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_value = value_ff;

endmodule

`default_nettype wire

// ===== src/dtc_checker.sv =====
`default_nettype none

module dtc_checker
   import dtc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        req_kind,
   input wire logic        rsp_strobe,
   input wire logic [15:0] rsp_result_value
);

   // Every beat taken comes out as a result strobe unless reset cut in
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy, 3) && !$past(reset, 3) && !$past(reset, 2)
         && !$past(reset, 1)) |-> rsp_strobe)
      else $error("accepted beat produced no result");

   // No result without a beat taken earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy, 3) && !$past(reset, 3)))
      else $error("result without an accepted beat");

   // An encode result is an 8-bit code
   a_enc_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_kind, 3) == KIND_ENCODE))
         |-> (rsp_result_value[15:8] == 8'h00))
      else $error("encode result wider than a code");

   // A decode result never exceeds the longest dead time of the coarsest range
   a_dec_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_kind, 3) == KIND_DECODE))
         |-> (rsp_result_value <= DEC_MAX_NS))
      else $error("decode result out of range");

endmodule

bind dead_time_code_converter_top dtc_checker u_dtc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_kind         (req_kind),
   .rsp_strobe       (rsp_strobe),
   .rsp_result_value (rsp_result_value)
);

`default_nettype wire
